@@ rtl/core/stsg_pkg.sv @@
// ----------------------------------------------------------------------------
// Sine taper package
// Shared constants, beat types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package stsg_pkg;

  localparam int MaxLength    = 4096;
  localparam int LenW         = 13;
  localparam int IdxW         = 12;
  localparam int GainW        = 17;
  localparam int ModW         = 14;
  localparam int ProdW        = 25;
  localparam int PhaseBits    = 18;
  localparam int FracBits     = 16;
  localparam int OutW         = 18;
  localparam int ModSteps     = 25;
  localparam int PhaseSteps   = 18;
  localparam int CordicStages = 24;
  localparam int StepW        = 5;
  localparam int CordicX0     = 652032874;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    RegOrder  = 2'd0,
    RegLength = 2'd1,
    RegGain   = 2'd2
  } reg_e;

  typedef logic signed [31:0] cxy_t;
  typedef logic signed [32:0] ang_t;

  // Flags that ride along with every beat.
  typedef struct packed {
    logic in_range;
    logic last;
  } pl_t;

  // One restoring division step: partial remainder, dividend bits / quotient.
  typedef struct packed {
    logic [ModW-1:0]  rem;
    logic [ProdW-1:0] work;
    pl_t              pl;
  } div_t;

  typedef struct packed {
    cxy_t x;
    cxy_t y;
    ang_t z;
    pl_t  pl;
  } cordic_t;

  // atan(2^-s) in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [StepW-1:0] s);
    logic [31:0] a;
    case (s)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2F9;
      5'd15:   a = 32'h0000517C;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A2F;
      5'd19:   a = 32'h00000517;
      5'd20:   a = 32'h0000028B;
      5'd21:   a = 32'h00000145;
      5'd22:   a = 32'h000000A2;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/core/stsg_div_cell.sv @@
// ----------------------------------------------------------------------------
// Restoring division cell
// One quotient bit per cell; the partial remainder moves to the next cell.
// ----------------------------------------------------------------------------
module stsg_div_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  stsg_pkg::div_t        data_i,
  input  logic [stsg_pkg::ModW-1:0] divisor_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output stsg_pkg::div_t        data_o
);
  import stsg_pkg::*;

  logic [ModW:0] trial;
  logic          ge;
  logic [ModW:0] diff;
  div_t          step_d, step_q;
  logic          valid_q;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  assign trial = {data_i.rem, data_i.work[ProdW-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    step_d.rem  = ge ? diff[ModW-1:0] : trial[ModW-1:0];
    step_d.work = {data_i.work[ProdW-2:0], ge};
    step_d.pl   = data_i.pl;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      step_q <= step_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = step_q;

endmodule

@@ rtl/core/stsg_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// CORDIC rotation cell
// One micro-rotation of the rotation-mode CORDIC per cell.
// ----------------------------------------------------------------------------
module stsg_cordic_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [stsg_pkg::StepW-1:0] step_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  stsg_pkg::cordic_t          data_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output stsg_pkg::cordic_t          data_o
);
  import stsg_pkg::*;

  cxy_t    xs, ys;
  ang_t    a;
  cordic_t rot_d, rot_q;
  logic    valid_q;

  // Shifted copies and the angle of this step.
  assign xs = data_i.x >>> step_i;
  assign ys = data_i.y >>> step_i;
  assign a  = {1'b0, atan_turn(step_i)};

  always_comb begin
    rot_d.pl = data_i.pl;
    if (!data_i.z[32]) begin
      rot_d.x = data_i.x - ys;
      rot_d.y = data_i.y + xs;
      rot_d.z = data_i.z - a;
    end else begin
      rot_d.x = data_i.x + ys;
      rot_d.y = data_i.y - xs;
      rot_d.z = data_i.z + a;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      rot_q <= rot_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = rot_q;

endmodule

@@ rtl/core/sine_taper_sample_generator_unit.sv @@
// ----------------------------------------------------------------------------
// Sine taper sample generator
// Throughput: one sample per cycle while out_stall_i is low, set by the
// fully pipelined chains of 43 division cells and 24 CORDIC cells.
// Reset: clears all pipeline valid bits and loads the register defaults
// (order 0, length 64, gain 11497).
// ----------------------------------------------------------------------------
module sine_taper_sample_generator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [stsg_pkg::IdxW-1:0]     sample_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [stsg_pkg::OutW-1:0] taper_sample_o,
  output logic                          index_valid_o,
  output logic                          last_sample_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import stsg_pkg::*;

  // Configuration registers.
  logic [IdxW-1:0]  taper_order_q;
  logic [LenW-1:0]  taper_length_q;
  logic [GainW-1:0] taper_gain_q;
  reg_e             reg_sel;

  assign reg_sel = reg_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taper_order_q  <= '0;
      taper_length_q <= LenW'(64);
      taper_gain_q   <= GainW'(11497);
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        RegOrder:  taper_order_q  <= pwdata[IdxW-1:0];
        RegLength: taper_length_q <= pwdata[LenW-1:0];
        RegGain:   taper_gain_q   <= pwdata[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegOrder:  prdata = {20'b0, taper_order_q};
      RegLength: prdata = {19'b0, taper_length_q};
      RegGain:   prdata = {15'b0, taper_gain_q};
      default:   prdata = '0;
    endcase
  end

  // Clamped length and the modulus 2(N+1) derived from it.
  logic [LenW-1:0] len_eff;
  logic [LenW-1:0] len_p1;
  logic [ModW-1:0] modulus;

  assign len_eff = (taper_length_q > LenW'(MaxLength)) ? LenW'(MaxLength) : taper_length_q;
  assign len_p1  = len_eff + 1'b1;
  assign modulus = {len_p1, 1'b0};

  // Entry stage: range flags and the product (k+1)(i+1).
  logic            ent_v_q, ent_rdy;
  div_t            ent_q;
  logic [LenW-1:0] idx_ext;
  logic [ProdW-1:0] prod_full;

  assign idx_ext   = {1'b0, sample_index_i};
  assign prod_full = ({1'b0, taper_order_q} + 1'b1) * (idx_ext + 1'b1);

  logic [ModSteps:0]   mod_v, mod_rdy;
  div_t                mod_d [0:ModSteps];
  logic [PhaseSteps:0] ph_v, ph_rdy;
  div_t                ph_d  [0:PhaseSteps];

  assign ent_rdy    = !ent_v_q || mod_rdy[0];
  assign in_stall_o = !ent_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= 1'b0;
    end else if (ent_rdy) begin
      ent_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_rdy) begin
      ent_q.rem         <= '0;
      ent_q.work        <= prod_full;
      ent_q.pl.in_range <= idx_ext < len_eff;
      ent_q.pl.last     <= idx_ext == (len_eff - 1'b1);
    end
  end

  // Modulo chain: remainder of the product by 2(N+1).
  assign mod_v[0] = ent_v_q;
  assign mod_d[0] = ent_q;

  for (genvar j = 0; j < ModSteps; j++) begin : g_mod
    stsg_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (mod_v[j]),
      .ready_o   (mod_rdy[j]),
      .data_i    (mod_d[j]),
      .divisor_i (modulus),
      .valid_o   (mod_v[j+1]),
      .ready_i   (mod_rdy[j+1]),
      .data_o    (mod_d[j+1])
    );
  end

  // Phase chain: (r * 2^18 + (N+1)) / 2(N+1); the remainder seeds the division.
  assign mod_rdy[ModSteps] = ph_rdy[0];
  assign ph_v[0]           = mod_v[ModSteps];
  always_comb begin
    ph_d[0].rem  = mod_d[ModSteps].rem;
    ph_d[0].work = {5'b0, len_p1, 7'b0};
    ph_d[0].pl   = mod_d[ModSteps].pl;
  end

  for (genvar j = 0; j < PhaseSteps; j++) begin : g_phase
    stsg_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (ph_v[j]),
      .ready_o   (ph_rdy[j]),
      .data_i    (ph_d[j]),
      .divisor_i (modulus),
      .valid_o   (ph_v[j+1]),
      .ready_i   (ph_rdy[j+1]),
      .data_o    (ph_d[j+1])
    );
  end

  // Fold stage: map the phase into [-1/4, +1/4] turn and seed the CORDIC.
  logic [CordicStages:0] c_v, c_rdy;
  cordic_t               c_d [0:CordicStages];
  logic                  fold_v_q, fold_rdy;
  cordic_t               fold_q;
  ang_t                  ang, ang_f;

  assign ang      = ang_t'($signed({ph_d[PhaseSteps].work[PhaseBits-1:0], 14'b0}));
  assign fold_rdy = !fold_v_q || c_rdy[0];
  assign ph_rdy[PhaseSteps] = fold_rdy;

  always_comb begin
    if (ang > ang_t'(33'sh040000000)) begin
      ang_f = ang_t'(33'sh080000000) - ang;
    end else if (ang < -ang_t'(33'sh040000000)) begin
      ang_f = -ang_t'(33'sh080000000) - ang;
    end else begin
      ang_f = ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_v_q <= 1'b0;
    end else if (fold_rdy) begin
      fold_v_q <= ph_v[PhaseSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fold_rdy) begin
      fold_q.x  <= cxy_t'(CordicX0);
      fold_q.y  <= '0;
      fold_q.z  <= ang_f;
      fold_q.pl <= ph_d[PhaseSteps].pl;
    end
  end

  // CORDIC chain.
  assign c_v[0] = fold_v_q;
  assign c_d[0] = fold_q;

  for (genvar j = 0; j < CordicStages; j++) begin : g_cordic
    stsg_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (StepW'(j)),
      .valid_i (c_v[j]),
      .ready_o (c_rdy[j]),
      .data_i  (c_d[j]),
      .valid_o (c_v[j+1]),
      .ready_i (c_rdy[j+1]),
      .data_o  (c_d[j+1])
    );
  end

  // Gain multiply.
  logic                      mul_v_q, mul_rdy, out_rdy;
  logic signed [49:0]        mul_q;
  pl_t                       mul_pl_q;

  assign mul_rdy                = !mul_v_q || out_rdy;
  assign c_rdy[CordicStages]    = mul_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
    end else if (mul_rdy) begin
      mul_v_q <= c_v[CordicStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_rdy) begin
      mul_q    <= c_d[CordicStages].y * $signed({1'b0, taper_gain_q});
      mul_pl_q <= c_d[CordicStages].pl;
    end
  end

  // Round half up, saturate, and zero an out-of-range index.
  logic signed [49:0] rnd_full;
  logic signed [19:0] rnd;
  logic signed [OutW-1:0] smp;
  logic               out_v_q;
  logic signed [OutW-1:0] smp_q;
  pl_t                out_pl_q;

  assign rnd_full = (mul_q + 50'sd536870912) >>> 30;
  assign rnd      = rnd_full[19:0];

  always_comb begin
    if (!mul_pl_q.in_range) begin
      smp = '0;
    end else if (rnd > 20'sd65536) begin
      smp = 18'sd65536;
    end else if (rnd < -20'sd65536) begin
      smp = -18'sd65536;
    end else begin
      smp = rnd[OutW-1:0];
    end
  end

  assign out_rdy = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= mul_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      smp_q       <= smp;
      out_pl_q    <= mul_pl_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign taper_sample_o = smp_q;
  assign index_valid_o  = out_pl_q.in_range;
  assign last_sample_o  = out_pl_q.last;

endmodule

@@ dv/sine_taper_checker.sv @@
// ----------------------------------------------------------------------------
// Sine taper result checker
// Watches the sample and result channels, computes the expected taper sample
// for every accepted index beat and compares each result beat in order.
// ----------------------------------------------------------------------------
module sine_taper_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [stsg_pkg::IdxW-1:0]           sample_index_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [stsg_pkg::OutW-1:0]    taper_sample_i,
  input  logic                                index_valid_i,
  input  logic                                last_sample_i,
  input  logic [11:0]                         order_i,
  input  logic [12:0]                         length_i,
  input  logic [16:0]                         gain_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import stsg_pkg::*;

  typedef struct packed {
    logic signed [OutW-1:0] sample;
    logic                   in_range;
    logic                   last;
  } taper_beat_t;

  taper_beat_t expected_taper_q[$];
  int          fails = 0;

  localparam longint unsigned QTurn = 64'd1073741824;
  localparam longint unsigned HTurn = 64'd2147483648;

  // Floor division by a power of two for signed values.
  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-(v + 1)) >>> s) - 1;
  endfunction

  // Rotation-mode CORDIC sine, angle in 2^-32 turn, result Q30.
  function automatic longint sine_q30(longint ang);
    longint x, y, z, nx;
    x = CordicX0;
    y = 0;
    if (ang > longint'(QTurn)) ang = longint'(HTurn) - ang;
    else if (ang < -longint'(QTurn)) ang = -longint'(HTurn) - ang;
    z = ang;
    for (int s = 0; s < CordicStages; s++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, s);
        y  = y + floor_shift(x, s);
        z  = z - longint'(atan_turn(s[StepW-1:0]));
      end else begin
        nx = x + floor_shift(y, s);
        y  = y - floor_shift(x, s);
        z  = z + longint'(atan_turn(s[StepW-1:0]));
      end
      x = nx;
    end
    return y;
  endfunction

  function automatic taper_beat_t taper_value(logic [IdxW-1:0] idx);
    taper_beat_t b;
    longint unsigned len, m, r, phase;
    longint ang, prod, smp, lim;
    b = '0;
    len = length_i;
    if (len > MaxLength) len = MaxLength;
    if (idx >= len) return b;
    m = 2 * (len + 1);
    r = ((longint'(order_i) + 1) * (longint'(idx) + 1)) % m;
    phase = ((r << PhaseBits) + m / 2) / m;
    phase &= (64'd1 << PhaseBits) - 1;
    ang = longint'(phase << (32 - PhaseBits));
    if (ang >= longint'(HTurn)) ang -= 2 * longint'(HTurn);
    prod = sine_q30(ang) * longint'(gain_i);
    smp = floor_shift(prod + (64'sd1 <<< (45 - FracBits)), 46 - FracBits);
    lim = 64'sd1 <<< FracBits;
    if (smp > lim) smp = lim;
    if (smp < -lim) smp = -lim;
    b.sample = smp[OutW-1:0];
    b.in_range = 1'b1;
    b.last = (idx == len - 1);
    return b;
  endfunction

  assign pending_o    = expected_taper_q.size();
  assign fail_count_o = fails;

  // Predict on accepted index beats, compare on accepted result beats.
  always @(posedge clk_i) begin
    taper_beat_t exp_b;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) expected_taper_q.push_back(taper_value(sample_index_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_taper_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("Unexpected result beat %0d", taper_sample_i);
        end else begin
          exp_b = expected_taper_q.pop_front();
          if (exp_b.sample !== taper_sample_i || exp_b.in_range !== index_valid_i ||
              exp_b.last !== last_sample_i) begin
            fails++;
            if (fails <= 10)
              $display("Mismatch: expected sample %0d valid %0b last %0b, got %0d %0b %0b",
                       exp_b.sample, exp_b.in_range, exp_b.last,
                       taper_sample_i, index_valid_i, last_sample_i);
          end
        end
      end
    end
  end

endmodule

@@ dv/tb_sine_taper_sample_generator_unit.sv @@
// ----------------------------------------------------------------------------
// Sine taper generator testbench
// Drives index beats and register settings, throttles both channels at
// random and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_sine_taper_sample_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import stsg_pkg::*;

  localparam int Latency = 71;
  localparam int WatchLimit = 4000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [IdxW-1:0] sample_index_i;
  logic signed [OutW-1:0] taper_sample_o;
  logic index_valid_o, last_sample_o;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic [11:0] order_shadow;
  logic [12:0] length_shadow;
  logic [16:0] gain_shadow;
  int fail_count, pending;
  int idle_cycles = 0;
  bit quiet_mode;

  sine_taper_sample_generator_unit dut (.*);

  sine_taper_checker checker_u (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .sample_index_i,
    .out_valid_i(out_valid_o), .out_stall_i, .taper_sample_i(taper_sample_o),
    .index_valid_i(index_valid_o), .last_sample_i(last_sample_o),
    .order_i(order_shadow), .length_i(length_shadow), .gain_i(gain_shadow),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog on cycles without any accepted beat or register access.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side stalls in random bursts.
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  task automatic write_reg(reg_e r, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 4'(r) << 2; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (r)
      RegOrder:  order_shadow <= v[11:0];
      RegLength: length_shadow <= v[12:0];
      default:   gain_shadow <= v[16:0];
    endcase
  endtask

  task automatic drain_results();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic send_index(logic [IdxW-1:0] idx, bit gaps);
    int n;
    if (gaps && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 13);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic configure(logic [11:0] k, logic [12:0] len, logic [16:0] g);
    write_reg(RegOrder, k);
    write_reg(RegLength, len);
    write_reg(RegGain, g);
  endtask

  // Random index mostly within the length, sometimes beyond it.
  function automatic logic [IdxW-1:0] pick_index();
    int lim;
    lim = (length_shadow > MaxLength) ? MaxLength : int'(length_shadow);
    if (lim > 0 && $urandom_range(0, 9) != 0) return IdxW'($urandom_range(0, lim - 1));
    return IdxW'($urandom);
  endfunction

  initial begin
    in_valid_i = 1'b0; sample_index_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    order_shadow = 12'd0; length_shadow = 13'd64; gain_shadow = 17'd11497;
    quiet_mode = 1'b0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats under the reset settings: edges, last, out of range.
    send_index(12'd0, 0); send_index(12'd1, 0); send_index(12'd31, 0);
    send_index(12'd63, 0); send_index(12'd64, 0); send_index(12'd4095, 0);
    send_index(12'd2730, 1); send_index(12'd1365, 1);
    in_valid_i <= 1'b0;
    drain_results();

    // Zero length, oversized length, order above length, full gain.
    configure(12'd4095, 13'd0, 17'd65536);
    send_index(12'd0, 0); send_index(12'd4095, 0);
    in_valid_i <= 1'b0;
    drain_results();
    configure(12'd4095, 13'd8191, 17'd131071);
    send_index(12'd0, 0); send_index(12'd4095, 0); send_index(12'd2048, 0);
    in_valid_i <= 1'b0;
    drain_results();
    configure(12'd0, 13'd1, 17'd0);
    send_index(12'd0, 0); send_index(12'd1, 0);
    in_valid_i <= 1'b0;
    drain_results();
    configure(12'd2, 13'd4096, 17'd65535);
    send_index(12'd4095, 0); send_index(12'd0, 0); send_index(12'd2047, 0);
    in_valid_i <= 1'b0;
    drain_results();

    // Random phases, each with a new register setting.
    for (int ph = 0; ph < 10; ph++) begin
      configure(12'($urandom_range(0, 4095)),
                (ph % 3 == 0) ? 13'($urandom) : 13'($urandom_range(1, 300)),
                17'($urandom_range(0, 131071)));
      if (ph == 9) quiet_mode = 1'b1;
      for (int n = 0; n < 103; n++) send_index(pick_index(), !quiet_mode);
      in_valid_i <= 1'b0;
      drain_results();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
